[src/box2_pkg.sv]
// ----------------------------------------------------------------------------
// box2_pkg
// Shared constants and types for the 2x2 box-filter downsampler.
// ----------------------------------------------------------------------------
package box2_pkg;

    // widest input image the line store supports, in pixels
    localparam int MAX_COLS    = 1024;
    localparam int LINE_DEPTH  = MAX_COLS / 2;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);

    // column counter and effective-width widths
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int EFF_W       = COL_W + 1;

    // fixed field widths
    localparam int PIX_W       = 8;
    localparam int PAIR_W      = PIX_W + 1;
    localparam int SUM_W       = PIX_W + 3;
    localparam int COLS_W      = 11;
    localparam int ROWS_W      = 16;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_IMAGE_COLS = 2'd0;
    localparam cfg_index_t CFG_IMAGE_ROWS = 2'd1;

    // rounding offset for the mean of four pixels
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(2);

endpackage

[src/box2_ram.sv]
// ----------------------------------------------------------------------------
// box2_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module box2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write, and registered read; rd_data holds between reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/box_downsample_2x2.sv]
// ----------------------------------------------------------------------------
// box_downsample_2x2
// 2x2 box-filter downsampler for a raster-order 8-bit greyscale stream.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while pix_stall is low. The line store is
// read in the accept cycle and its data is used from stage 1 on the way to
// the output register, so each pixel touches at most one RAM port.
// Reset: counters, pending results and the previous pixel clear; the width
// and height registers return to 640 and 480. The line store is not cleared.
// ----------------------------------------------------------------------------
module box_downsample_2x2 (
    input  logic                             clk,
    input  logic                             rst_n,
    // pixel input
    input  logic                             pix_valid,
    output logic                             pix_stall,
    input  logic [box2_pkg::PIX_W-1:0]       pixel_in,
    // result output
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [box2_pkg::PIX_W-1:0]       pixel_out,
    output logic                             row_end,
    output logic                             frame_end,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [box2_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [box2_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import box2_pkg::*;

    // configuration
    logic [COLS_W-1:0]   image_cols_reg;
    logic [ROWS_W-1:0]   image_rows_reg;

    // position and previous pixel
    logic [COL_W-1:0]    col_count_reg,  col_count_next;
    logic [ROWS_W-1:0]   row_count_reg,  row_count_next;
    logic [PIX_W-1:0]    left_pixel_reg;

    // stage 1: waits for line-store data
    logic                s1_valid_reg,   s1_valid_next;
    logic [PAIR_W-1:0]   s1_pair_reg;
    logic                s1_re_reg;
    logic                s1_fe_reg;

    // output register
    logic                res_valid_reg,  res_valid_next;
    logic [PIX_W-1:0]    pixel_out_reg;
    logic                row_end_reg;
    logic                frame_end_reg;

    // decode
    logic                accept;
    logic                s1_adv;
    logic [EFF_W-1:0]    eff_cols;
    logic [COL_W-1:0]    out_cols;
    logic [ROWS_W-2:0]   out_rows;
    logic [COL_W-2:0]    out_col;
    logic [ROWS_W-2:0]   out_row;
    logic                in_block;
    logic                wr_line;
    logic                rd_line;
    logic [PAIR_W-1:0]   pair;
    logic                re_flag;
    logic                fe_flag;
    logic [PAIR_W-1:0]   line_rd_data;
    logic [SUM_W-1:0]    block_sum;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_cols_reg <= COLS_W'(640);
            image_rows_reg <= ROWS_W'(480);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IMAGE_COLS: image_cols_reg <= cfg_data[COLS_W-1:0];
                CFG_IMAGE_ROWS: image_rows_reg <= cfg_data[ROWS_W-1:0];
                default:        ;
            endcase
        end
    end

    // saturate the width at the line-store size
    always_comb
    begin
        if (int'(image_cols_reg) > MAX_COLS)
        begin
            eff_cols = EFF_W'(MAX_COLS);
        end
        else
        begin
            eff_cols = EFF_W'(image_cols_reg);
        end
    end

    assign out_cols = eff_cols[EFF_W-1:1];
    assign out_rows = image_rows_reg[ROWS_W-1:1];
    assign out_col  = col_count_reg[COL_W-1:1];
    assign out_row  = row_count_reg[ROWS_W-1:1];

    // handshake: stage 1 moves when the output register is free or drains
    assign s1_adv    = !res_valid_reg || !res_stall;
    assign pix_stall = s1_valid_reg && !s1_adv;
    assign accept    = pix_valid && !pix_stall;

    // block membership and flags for the current pixel
    assign in_block = col_count_reg[0]
                   && ({1'b0, out_col} < out_cols)
                   && (out_row < out_rows);
    assign wr_line  = accept && in_block && !row_count_reg[0];
    assign rd_line  = accept && in_block &&  row_count_reg[0];
    assign pair     = {1'b0, left_pixel_reg} + {1'b0, pixel_in};
    assign re_flag  = ({1'b0, out_col} + COL_W'(1)) == out_cols;
    assign fe_flag  = re_flag && ((out_row + (ROWS_W-1)'(1)) == out_rows);

    // line store of pair sums, one entry per output column
    box2_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_line),
        .wr_addr (out_col[LINE_AW-1:0]),
        .wr_data (pair),
        .rd_en   (rd_line),
        .rd_addr (out_col[LINE_AW-1:0]),
        .rd_data (line_rd_data)
    );

    // advance column and row counters, wrapping at the image size
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (({1'b0, col_count_reg} + EFF_W'(1)) >= eff_cols)
            begin
                col_count_next = '0;
                if (({1'b0, row_count_reg} + (ROWS_W+1)'(1)) >= {1'b0, image_rows_reg})
                begin
                    row_count_next = '0;
                end
                else
                begin
                    row_count_next = row_count_reg + ROWS_W'(1);
                end
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    // stage 1 and output valid
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = rd_line;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_adv)
        begin
            res_valid_next = s1_valid_reg;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // complete the block: stored pair plus current pair, rounded
    assign block_sum = SUM_W'(line_rd_data) + SUM_W'(s1_pair_reg) + ROUND_HALF;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            left_pixel_reg <= '0;
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                left_pixel_reg <= pixel_in;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pair_reg <= pair;
            s1_re_reg   <= re_flag;
            s1_fe_reg   <= fe_flag;
        end
        if (s1_adv && s1_valid_reg)
        begin
            pixel_out_reg <= block_sum[SUM_W-2:2];
            row_end_reg   <= s1_re_reg;
            frame_end_reg <= s1_fe_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule
